>>> hdl/xml_token_lexer_defines.svh
// assertion macros for the xml token lexer
`ifndef XML_TOKEN_LEXER_DEFINES_SVH
`define XML_TOKEN_LEXER_DEFINES_SVH
`ifndef SYNTH
`define LX_ASSERT(lbl, prop) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) \
    else $error("xml lexer check failed");
`define LX_ASSERT_IMP(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("xml lexer check failed");
`else
`define LX_ASSERT(lbl, prop)
`define LX_ASSERT_IMP(lbl, ante, cons)
`endif
`endif

>>> hdl/lx_pkg.sv
package lx_pkg;

  typedef enum logic [3:0] {
    TK_EOF       = 4'd0,
    TK_OPEN      = 4'd1,
    TK_CLOSEOPEN = 4'd2,
    TK_GT        = 4'd3,
    TK_SLASH     = 4'd4,
    TK_EQUALS    = 4'd5,
    TK_IDENT     = 4'd6,
    TK_STRING    = 4'd7,
    TK_COMMENT   = 4'd8,
    TK_CDATA     = 4'd9,
    TK_TEXT      = 4'd10,
    TK_ERROR     = 4'd11
  } tok_e;

  localparam int unsigned MaxRes = 4;
  localparam int unsigned RunCntW = $clog2(MaxRes + 1);
  localparam int unsigned ResIdxW = $clog2(MaxRes);
  localparam int unsigned FifoDepth = 4;
  localparam int unsigned FifoPtrW = $clog2(FifoDepth);
  localparam int unsigned FifoCntW = $clog2(FifoDepth + 1);

  localparam logic [7:0] ChLt    = 8'h3C;
  localparam logic [7:0] ChGt    = 8'h3E;
  localparam logic [7:0] ChSlash = 8'h2F;
  localparam logic [7:0] ChBang  = 8'h21;
  localparam logic [7:0] ChDash  = 8'h2D;
  localparam logic [7:0] ChLBr   = 8'h5B;
  localparam logic [7:0] ChRBr   = 8'h5D;
  localparam logic [7:0] ChEq    = 8'h3D;
  localparam logic [7:0] ChDq    = 8'h22;
  localparam logic [7:0] ChSq    = 8'h27;
  localparam logic [7:0] ChAmp   = 8'h26;
  localparam logic [7:0] ChNul   = 8'h00;

  typedef struct packed {
    logic       kind;
    tok_e       tt;
    logic [7:0] data;
  } res_t;

  typedef struct packed {
    logic [RunCntW-1:0]     n;
    res_t [MaxRes-1:0]      r;
  } run_t;

  function automatic run_t run_add(run_t run, logic kind, tok_e tt, logic [7:0] data);
    run_t o;
    o = run;
    if (run.n < RunCntW'(MaxRes)) begin
      o.r[run.n[ResIdxW-1:0]] = '{kind: kind, tt: tt, data: data};
      o.n = run.n + RunCntW'(1);
    end
    return o;
  endfunction

  function automatic logic is_space(logic [7:0] b);
    return (b == 8'd32) || (b >= 8'd9 && b <= 8'd13);
  endfunction

  function automatic logic is_ident(logic [7:0] b);
    return (b == 8'h2D) || (b == 8'h2E) || (b >= 8'h30 && b <= 8'h3A) ||
           (b >= 8'h41 && b <= 8'h5A) || (b == 8'h5F) || (b >= 8'h61 && b <= 8'h7A);
  endfunction

  // "<![CDATA[" by position
  function automatic logic [7:0] cdata_char(logic [3:0] i);
    logic [7:0] c;
    case (i)
      4'd0: c = 8'h3C;
      4'd1: c = 8'h21;
      4'd2: c = 8'h5B;
      4'd3: c = 8'h43;
      4'd4: c = 8'h44;
      4'd5: c = 8'h41;
      4'd6: c = 8'h54;
      4'd7: c = 8'h41;
      4'd8: c = 8'h5B;
      default: c = 8'h00;
    endcase
    return c;
  endfunction

  // entity walker: 0 no match, bit 8 set means done with decoded byte
  function automatic logic [8:0] ent_next(logic [3:0] st, logic [7:0] b);
    logic [8:0] r;
    r = 9'd0;
    case (st)
      4'd1: begin
        if (b == 8'h6C) r = 9'd2;
        else if (b == 8'h67) r = 9'd4;
        else if (b == 8'h61) r = 9'd6;
        else if (b == 8'h71) r = 9'd12;
      end
      4'd2: if (b == 8'h74) r = 9'd3;
      4'd3: if (b == 8'h3B) r = {1'b1, 8'h3C};
      4'd4: if (b == 8'h74) r = 9'd5;
      4'd5: if (b == 8'h3B) r = {1'b1, 8'h3E};
      4'd6: begin
        if (b == 8'h6D) r = 9'd7;
        else if (b == 8'h70) r = 9'd9;
      end
      4'd7: if (b == 8'h70) r = 9'd8;
      4'd8: if (b == 8'h3B) r = {1'b1, 8'h26};
      4'd9: if (b == 8'h6F) r = 9'd10;
      4'd10: if (b == 8'h73) r = 9'd11;
      4'd11: if (b == 8'h3B) r = {1'b1, 8'h27};
      4'd12: if (b == 8'h75) r = 9'd13;
      4'd13: if (b == 8'h6F) r = 9'd14;
      4'd14: if (b == 8'h74) r = 9'd15;
      4'd15: if (b == 8'h3B) r = {1'b1, 8'h22};
      default: r = 9'd0;
    endcase
    return r;
  endfunction

endpackage

>>> hdl/xml_token_lexer.sv
// xml token lexer: one document byte per cycle in while the run queue has a free slot,
//   one result word per cycle out while the output is not stalled; a byte's results
//   pass the run queue and then the output register; one byte per cycle flows while bytes
//   give one result at most and nothing stalls; a byte with more sends one word per result
// reset: asynchronous active low, lexer returns to between-tokens, queue empties
`include "xml_token_lexer_defines.svh"
module xml_token_lexer (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       in_valid_i,
  output logic       in_ready_o,
  input  logic [7:0] in_byte_i,
  input  logic       is_last_i,
  output logic       out_valid_o,
  input  logic       out_ready_i,
  output logic       kind_o,
  output logic [3:0] tok_code_o,
  output logic [7:0] data_byte_o,
  output logic       last_of_run_o
);
  import lx_pkg::*;

  logic                accept, push, pop;
  run_t                push_run, head;
  logic [FifoCntW-1:0] q_count;
  res_t                res;

  // front end takes a byte whenever the run queue has a free slot
  assign in_ready_o = (q_count != FifoCntW'(FifoDepth));
  assign accept     = in_valid_i && in_ready_o;

  // front: lexer state and classification of one byte into a run of results
  lx_front u_front (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .accept_i  (accept),
    .in_byte_i (in_byte_i),
    .is_last_i (is_last_i),
    .push_o    (push),
    .run_o     (push_run)
  );

  // queue of runs between front and back
  lx_fifo u_fifo (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .wdata_i (push_run),
    .pop_i   (pop),
    .rdata_o (head),
    .count_o (q_count)
  );

  // back: serializes a run into output words, one per cycle while the output is not stalled
  lx_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .avail_i     (q_count != '0),
    .head_i      (head),
    .pop_o       (pop),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .res_o       (res),
    .last_o      (last_of_run_o)
  );

  assign kind_o       = res.kind;
  assign tok_code_o   = res.tt;
  assign data_byte_o  = res.data;

  `LX_ASSERT(a_q_bound, q_count <= FifoCntW'(FifoDepth))
  `LX_ASSERT_IMP(a_run_len, push, (push_run.n != '0) && (push_run.n <= RunCntW'(MaxRes)))
  `LX_ASSERT_IMP(a_last_eof, accept && is_last_i, push)
  `LX_ASSERT_IMP(a_marker_zero, out_valid_o && kind_o, data_byte_o == 8'd0)
  `LX_ASSERT_IMP(a_content_tok, out_valid_o && !kind_o, (res.tt == TK_IDENT) || (res.tt == TK_STRING) || (res.tt == TK_COMMENT) || (res.tt == TK_CDATA) || (res.tt == TK_TEXT))

endmodule

>>> hdl/lx_front.sv
module lx_front (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          accept_i,
  input  logic [7:0]    in_byte_i,
  input  logic          is_last_i,
  output logic          push_o,
  output lx_pkg::run_t  run_o
);
  import lx_pkg::*;

  typedef enum logic [3:0] {
    M_IDLE = 4'd0, M_LT = 4'd1, M_BANG = 4'd2, M_PCOM = 4'd3, M_PCDATA = 4'd4,
    M_IDENT = 4'd5, M_TEXT = 4'd6, M_STRING = 4'd7, M_COMMENT = 4'd8, M_CDATA = 4'd9
  } mode_e;

  mode_e      mode_q, mode_d;
  logic       in_tag_q, in_tag_d, qs_q, qs_d, halted_q, halted_d;
  logic [3:0] pre_q, pre_d, ent_q, ent_d;
  logic [1:0] clos_q, clos_d;

  run_t       run;
  logic       disp, fail_f;
  logic [7:0] b, c, q;
  logic [8:0] er;
  tok_e       ctt;

  always_comb begin
    b = in_byte_i;
    run = '0;
    disp = 1'b0;
    fail_f = 1'b0;
    mode_d = mode_q;
    in_tag_d = in_tag_q;
    qs_d = qs_q;
    halted_d = halted_q;
    pre_d = pre_q;
    ent_d = ent_q;
    clos_d = clos_q;
    q = qs_q ? ChSq : ChDq;
    er = ent_next(ent_q, b);
    c = (mode_q == M_COMMENT) ? ChDash : ChRBr;
    ctt = (mode_q == M_COMMENT) ? TK_COMMENT : TK_CDATA;

    if (!halted_q) begin
      case (mode_q)
        M_LT: begin
          if (b == ChSlash) begin
            in_tag_d = 1'b1;
            run = run_add(run, 1'b1, TK_CLOSEOPEN, 8'd0);
            mode_d = M_IDLE;
          end else if (b == ChBang) begin
            mode_d = M_BANG;
            pre_d = 4'd2;
          end else begin
            in_tag_d = 1'b1;
            run = run_add(run, 1'b1, TK_OPEN, 8'd0);
            mode_d = M_IDLE;
            disp = 1'b1;
          end
        end
        M_BANG: begin
          if (b == ChDash) begin
            mode_d = M_PCOM;
            pre_d = 4'd3;
          end else if (b == ChLBr) begin
            mode_d = M_PCDATA;
            pre_d = 4'd3;
          end else begin
            in_tag_d = 1'b1;
            run = run_add(run, 1'b1, TK_OPEN, 8'd0);
            fail_f = 1'b1;
          end
        end
        M_PCOM: begin
          if (b == ChDash) begin
            mode_d = M_COMMENT;
            clos_d = 2'd0;
            pre_d = 4'd0;
          end else begin
            in_tag_d = 1'b1;
            run = run_add(run, 1'b1, TK_OPEN, 8'd0);
            fail_f = 1'b1;
          end
        end
        M_PCDATA: begin
          if (pre_q < 4'd9 && b == cdata_char(pre_q)) begin
            pre_d = pre_q + 4'd1;
            if (pre_q == 4'd8) begin
              mode_d = M_CDATA;
              clos_d = 2'd0;
              pre_d = 4'd0;
            end
          end else begin
            in_tag_d = 1'b1;
            run = run_add(run, 1'b1, TK_OPEN, 8'd0);
            fail_f = 1'b1;
          end
        end
        M_IDENT: begin
          if (is_ident(b)) begin
            run = run_add(run, 1'b0, TK_IDENT, b);
          end else begin
            run = run_add(run, 1'b1, TK_IDENT, 8'd0);
            mode_d = M_IDLE;
            disp = 1'b1;
          end
        end
        M_TEXT, M_STRING: begin
          if ((mode_q == M_TEXT && b == ChLt) || (mode_q == M_STRING && b == q)) begin
            if (ent_q != 4'd0) begin
              fail_f = 1'b1;
            end else if (mode_q == M_TEXT) begin
              run = run_add(run, 1'b1, TK_TEXT, 8'd0);
              mode_d = M_LT;
              pre_d = 4'd1;
            end else begin
              run = run_add(run, 1'b1, TK_STRING, 8'd0);
              mode_d = M_IDLE;
            end
          end else if (b == ChNul) begin
            fail_f = 1'b1;
          end else if (ent_q == 4'd0) begin
            if (b == ChAmp) ent_d = 4'd1;
            else run = run_add(run, 1'b0, (mode_q == M_TEXT) ? TK_TEXT : TK_STRING, b);
          end else if (er == 9'd0) begin
            fail_f = 1'b1;
          end else if (er[8]) begin
            run = run_add(run, 1'b0, (mode_q == M_TEXT) ? TK_TEXT : TK_STRING, er[7:0]);
            ent_d = 4'd0;
          end else begin
            ent_d = er[3:0];
          end
        end
        M_COMMENT, M_CDATA: begin
          if (b == ChNul) begin
            fail_f = 1'b1;
          end else if (b == c) begin
            if (clos_q < 2'd2) clos_d = clos_q + 2'd1;
            else run = run_add(run, 1'b0, ctt, c);
          end else if (b == ChGt && clos_q == 2'd2) begin
            run = run_add(run, 1'b1, ctt, 8'd0);
            mode_d = M_IDLE;
            clos_d = 2'd0;
          end else if (is_last_i) begin
            fail_f = 1'b1;
          end else begin
            if (clos_q >= 2'd1) run = run_add(run, 1'b0, ctt, c);
            if (clos_q >= 2'd2) run = run_add(run, 1'b0, ctt, c);
            clos_d = 2'd0;
            run = run_add(run, 1'b0, ctt, b);
          end
        end
        default: begin
          mode_d = M_IDLE;
          disp = 1'b1;
        end
      endcase

      // start of a new token
      if (disp) begin
        if (is_space(b)) begin
          mode_d = mode_d;
        end else if (b == ChNul) begin
          halted_d = 1'b1;
          mode_d = M_IDLE;
        end else if (b == ChLt) begin
          mode_d = M_LT;
          pre_d = 4'd1;
        end else if (b == ChGt) begin
          in_tag_d = 1'b0;
          run = run_add(run, 1'b1, TK_GT, 8'd0);
        end else if (in_tag_d) begin
          if (b == ChSlash) begin
            run = run_add(run, 1'b1, TK_SLASH, 8'd0);
          end else if (b == ChEq) begin
            run = run_add(run, 1'b1, TK_EQUALS, 8'd0);
          end else if (b == ChDq || b == ChSq) begin
            mode_d = M_STRING;
            qs_d = (b == ChSq);
            ent_d = 4'd0;
          end else if (is_ident(b)) begin
            mode_d = M_IDENT;
            run = run_add(run, 1'b0, TK_IDENT, b);
          end else begin
            fail_f = 1'b1;
          end
        end else begin
          mode_d = M_TEXT;
          if (b == ChAmp) begin
            ent_d = 4'd1;
          end else begin
            ent_d = 4'd0;
            run = run_add(run, 1'b0, TK_TEXT, b);
          end
        end
      end

      if (fail_f) begin
        run = run_add(run, 1'b1, TK_ERROR, 8'd0);
        halted_d = 1'b1;
        mode_d = M_IDLE;
        ent_d = 4'd0;
        clos_d = 2'd0;
        pre_d = 4'd0;
      end
    end

    // end of document
    if (is_last_i) begin
      if (!halted_d) begin
        case (mode_d)
          M_LT: run = run_add(run, 1'b1, TK_OPEN, 8'd0);
          M_BANG, M_PCOM, M_PCDATA: begin
            run = run_add(run, 1'b1, TK_OPEN, 8'd0);
            run = run_add(run, 1'b1, TK_ERROR, 8'd0);
          end
          M_IDENT: run = run_add(run, 1'b1, TK_IDENT, 8'd0);
          M_TEXT: begin
            if (ent_d != 4'd0) run = run_add(run, 1'b1, TK_ERROR, 8'd0);
            else run = run_add(run, 1'b1, TK_TEXT, 8'd0);
          end
          M_STRING, M_COMMENT, M_CDATA: run = run_add(run, 1'b1, TK_ERROR, 8'd0);
          default: run = run;
        endcase
      end
      run = run_add(run, 1'b1, TK_EOF, 8'd0);
      mode_d = M_IDLE;
      in_tag_d = 1'b0;
      qs_d = 1'b0;
      halted_d = 1'b0;
      pre_d = 4'd0;
      ent_d = 4'd0;
      clos_d = 2'd0;
    end
  end

  assign push_o = accept_i && (run.n != '0);
  assign run_o  = run;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q <= M_IDLE;
      in_tag_q <= 1'b0;
      qs_q <= 1'b0;
      halted_q <= 1'b0;
      pre_q <= 4'd0;
      ent_q <= 4'd0;
      clos_q <= 2'd0;
    end else if (accept_i) begin
      mode_q <= mode_d;
      in_tag_q <= in_tag_d;
      qs_q <= qs_d;
      halted_q <= halted_d;
      pre_q <= pre_d;
      ent_q <= ent_d;
      clos_q <= clos_d;
    end
  end

endmodule

>>> hdl/lx_fifo.sv
module lx_fifo (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           push_i,
  input  lx_pkg::run_t                   wdata_i,
  input  logic                           pop_i,
  output lx_pkg::run_t                   rdata_o,
  output logic [lx_pkg::FifoCntW-1:0]    count_o
);
  import lx_pkg::*;

  run_t                mem_q [FifoDepth];
  logic [FifoPtrW-1:0] wr_q, rd_q;
  logic [FifoCntW-1:0] cnt_q;
  logic                do_push, do_pop;

  assign do_push = push_i && (cnt_q != FifoCntW'(FifoDepth));
  assign do_pop  = pop_i && (cnt_q != '0);
  assign rdata_o = mem_q[rd_q];
  assign count_o = cnt_q;

  always_ff @(posedge clk_i) begin
    if (do_push) mem_q[wr_q] <= wdata_i;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q <= '0;
      rd_q <= '0;
      cnt_q <= '0;
    end else begin
      if (do_push) wr_q <= wr_q + FifoPtrW'(1);
      if (do_pop) rd_q <= rd_q + FifoPtrW'(1);
      cnt_q <= cnt_q + FifoCntW'(do_push) - FifoCntW'(do_pop);
    end
  end

endmodule

>>> hdl/lx_back.sv
module lx_back (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          avail_i,
  input  lx_pkg::run_t  head_i,
  output logic          pop_o,
  output logic          out_valid_o,
  input  logic          out_ready_i,
  output lx_pkg::res_t  res_o,
  output logic          last_o
);
  import lx_pkg::*;

  logic [ResIdxW-1:0] idx_q;
  logic               valid_q, last_q, load, fin;
  res_t               res_q;

  assign load  = avail_i && (!valid_q || out_ready_i);
  assign fin   = (RunCntW'(idx_q) + RunCntW'(1)) == head_i.n;
  assign pop_o = load && fin;

  always_ff @(posedge clk_i) begin
    if (load) begin
      res_q  <= head_i.r[idx_q];
      last_q <= fin;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
      idx_q <= '0;
    end else begin
      if (load) begin
        valid_q <= 1'b1;
        idx_q <= fin ? '0 : idx_q + ResIdxW'(1);
      end else if (out_ready_i) begin
        valid_q <= 1'b0;
      end
    end
  end

  assign out_valid_o = valid_q;
  assign res_o       = res_q;
  assign last_o      = last_q;

endmodule
